@@ rtl/core/lscr_pkg.sv @@
package lscr_pkg;

  localparam int VAL_W  = 10;
  localparam int ADDR_W = 3;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_SYNC   = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_REPORT_SLOT = 1'b0;

  localparam logic [VAL_W-1:0] REPORT_SLOT_RESET = 10'd30;
  localparam logic [VAL_W-1:0] SYNC_TIME         = 10'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_SCAN,
    ST_PLACE,
    ST_REPORT_SORT,
    ST_EMIT,
    ST_HOLD
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SCAN_INIT,
    OP_SORT_STEP,
    OP_SCAN_STEP,
    OP_PLACE,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic gt;
    logic free_any;
    logic idx_valid;
    logic later_valid;
  } stat_t;

endpackage

@@ rtl/core/lscr_if.sv @@
interface lscr_in_if;
  import lscr_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       command;
  logic [VAL_W-1:0] sample_level;

  modport source (output valid, command, sample_level, input ready);
  modport sink (input valid, command, sample_level, output ready);
endinterface

interface lscr_out_if;
  import lscr_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] peak_level;
  logic [VAL_W-1:0] capture_time;
  logic             last_of_burst;

  modport source (output valid, peak_level, capture_time, last_of_burst, input ready);
  modport sink (input valid, peak_level, capture_time, last_of_burst, output ready);
endinterface

@@ rtl/core/lscr_slots.sv @@
module lscr_slots
  import lscr_pkg::*;
#(
  parameter int SLOTS = 4,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             rst,
  input  ctl_t             ctl,
  input  logic [IDX_W-1:0] idx,
  input  logic [VAL_W-1:0] sample,
  input  logic [VAL_W-1:0] frame_time,
  output stat_t            stat,
  output logic [VAL_W-1:0] rd_level,
  output logic [VAL_W-1:0] rd_time
);

  logic [VAL_W-1:0] level [SLOTS];
  logic [VAL_W-1:0] stamp [SLOTS];
  logic [SLOTS-1:0] valid;
  logic [IDX_W-1:0] best;

  logic [IDX_W-1:0] idx_nx;
  logic [IDX_W-1:0] free_idx;
  logic             free_any;
  logic             later;
  logic [VAL_W-1:0] cmp_a;
  logic [VAL_W-1:0] cmp_b;
  logic             gt;

  assign idx_nx = idx + IDX_W'(1);

  // shared comparator
  always_comb begin
    case (ctl.op)
      OP_SORT_STEP: begin
        cmp_a = stamp[idx];
        cmp_b = stamp[idx_nx];
      end
      OP_SCAN_STEP: begin
        cmp_a = level[best];
        cmp_b = level[idx];
      end
      OP_PLACE: begin
        cmp_a = sample;
        cmp_b = level[best];
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  assign gt = cmp_a > cmp_b;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    later = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (IDX_W'(i) > idx && valid[i]) begin
        later = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      best  <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        level[i] <= '0;
        stamp[i] <= '0;
      end
    end else begin
      case (ctl.op)
        OP_SCAN_INIT: begin
          best <= '0;
        end
        OP_SORT_STEP: begin
          if (gt) begin
            level[idx]    <= level[idx_nx];
            stamp[idx]    <= stamp[idx_nx];
            valid[idx]    <= valid[idx_nx];
            level[idx_nx] <= level[idx];
            stamp[idx_nx] <= stamp[idx];
            valid[idx_nx] <= valid[idx];
          end
        end
        OP_SCAN_STEP: begin
          if (gt) begin
            best <= idx;
          end
        end
        OP_PLACE: begin
          if (free_any) begin
            level[free_idx] <= sample;
            stamp[free_idx] <= frame_time;
            valid[free_idx] <= 1'b1;
          end else if (gt) begin
            level[best] <= sample;
            stamp[best] <= frame_time;
            valid[best] <= 1'b1;
          end
        end
        OP_CLEAR: begin
          level[idx] <= '0;
          stamp[idx] <= '0;
          valid[idx] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.gt          = gt;
  assign stat.free_any    = free_any;
  assign stat.idx_valid   = valid[idx];
  assign stat.later_valid = later;
  assign rd_level         = level[idx];
  assign rd_time          = stamp[idx];

endmodule

@@ rtl/core/lscr_seq.sv @@
module lscr_seq
  import lscr_pkg::*;
#(
  parameter int SLOTS = 4,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_accept,
  input  logic [1:0]       command,
  input  logic             out_accept,
  input  logic             report_hit,
  input  stat_t            stat,
  output ctl_t             ctl,
  output logic [IDX_W-1:0] idx,
  output logic             in_ready
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [IDX_W-1:0] LAST_CMP = IDX_W'(SLOTS - 2);

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] pass;
  logic             pass_end;
  logic             sort_end;
  logic             start;

  assign pass_end = (k == LAST_CMP - pass);
  assign sort_end = pass_end && (pass == LAST_CMP);
  assign start    = in_accept && (command == CMD_SAMPLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SORT;
        end
      end
      ST_SORT: begin
        if (sort_end) begin
          state_next = stat.free_any ? ST_PLACE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (k == LAST_IDX) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        state_next = report_hit ? ST_REPORT_SORT : ST_IDLE;
      end
      ST_REPORT_SORT: begin
        if (sort_end) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.idx_valid) begin
          state_next = ST_HOLD;
        end else if (k == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (out_accept) begin
          state_next = (k == LAST_IDX) ? ST_IDLE : ST_EMIT;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl.op       = OP_NONE;
    ctl.load_out = 1'b0;
    in_ready     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (start) begin
          ctl.op = OP_SCAN_INIT;
        end
      end
      ST_SORT, ST_REPORT_SORT: begin
        ctl.op = OP_SORT_STEP;
      end
      ST_SCAN: begin
        ctl.op = OP_SCAN_STEP;
      end
      ST_PLACE: begin
        ctl.op = OP_PLACE;
      end
      ST_EMIT: begin
        if (stat.idx_valid) begin
          ctl.op       = OP_CLEAR;
          ctl.load_out = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
      pass  <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_SORT, ST_REPORT_SORT: begin
          if (pass_end) begin
            pass <= pass + IDX_W'(1);
            k    <= (state == ST_SORT && sort_end) ? IDX_W'(1) : '0;
          end else begin
            k <= k + IDX_W'(1);
          end
        end
        ST_SCAN: begin
          k <= (k == LAST_IDX) ? '0 : k + IDX_W'(1);
        end
        ST_EMIT: begin
          if (!stat.idx_valid) begin
            k <= (k == LAST_IDX) ? '0 : k + IDX_W'(1);
          end
        end
        ST_HOLD: begin
          if (out_accept) begin
            k <= (k == LAST_IDX) ? '0 : k + IDX_W'(1);
          end
        end
        default: begin
          k    <= '0;
          pass <= '0;
        end
      endcase
    end
  end

  assign idx = k;

endmodule

@@ rtl/core/loudest_sample_capture_report.sv @@
// Keeps the SLOTS loudest samples of a frame with their capture times and
// reports them, oldest first, after a sample taken while the frame counter
// equals report_slot. Ticks, syncs and unused commands are handled in idle.
// A sample takes SLOTS*(SLOTS-1)/2 sort steps, SLOTS-1 search steps more
// when all slots are full, and a place step; a report adds another
// SLOTS*(SLOTS-1)/2 sort steps, then emits each valid slot in turn and
// holds it until the output takes it. The single compare unit is used once
// per step for the bubble sort, the quietest-slot search and the replace
// decision. No request is taken while a sample or report is under way.
// report_slot is at byte address 0 of the register port.
module loudest_sample_capture_report
  import lscr_pkg::*;
#(
  parameter int SLOTS        = 4,
  parameter int FRAME_LENGTH = 1000
) (
  input  logic              clk,
  input  logic              rst,
  lscr_in_if.sink           sample_ch,
  lscr_out_if.source        report_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [VAL_W-1:0] FRAME_TOP = VAL_W'(FRAME_LENGTH);

  logic [VAL_W-1:0] report_slot;
  logic [VAL_W-1:0] frame_counter;
  logic [VAL_W-1:0] sample;
  logic             in_accept;
  logic             out_accept;
  ctl_t             ctl;
  stat_t            stat;
  logic [IDX_W-1:0] idx;
  logic [VAL_W-1:0] rd_level;
  logic [VAL_W-1:0] rd_time;
  logic             in_ready;
  logic             out_valid;

  assign in_accept  = sample_ch.valid && in_ready;
  assign out_accept = out_valid && report_ch.ready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_REPORT_SLOT) ? 32'(report_slot) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_slot <= REPORT_SLOT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_REPORT_SLOT) begin
      report_slot <= pwdata[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter <= '0;
    end else if (in_accept) begin
      case (sample_ch.command)
        CMD_TICK: begin
          frame_counter <= (frame_counter < FRAME_TOP) ? frame_counter + VAL_W'(1) : '0;
        end
        CMD_SYNC: begin
          frame_counter <= SYNC_TIME;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample <= sample_ch.sample_level;
    end
  end

  lscr_seq #(.SLOTS(SLOTS)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_accept  (in_accept),
    .command    (sample_ch.command),
    .out_accept (out_accept),
    .report_hit (frame_counter == report_slot),
    .stat       (stat),
    .ctl        (ctl),
    .idx        (idx),
    .in_ready   (in_ready)
  );

  lscr_slots #(.SLOTS(SLOTS)) u_slots (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .idx        (idx),
    .sample     (sample),
    .frame_time (frame_counter),
    .stat       (stat),
    .rd_level   (rd_level),
    .rd_time    (rd_time)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      report_ch.peak_level    <= rd_level;
      report_ch.capture_time  <= rd_time;
      report_ch.last_of_burst <= !stat.later_valid;
    end
  end

  assign sample_ch.ready = in_ready;
  assign report_ch.valid = out_valid;

endmodule

@@ rtl/core/lscr_checker.sv @@
module lscr_checker
  import lscr_pkg::*;
#(
  parameter int FRAME_LENGTH = 1000
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [1:0]       command,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VAL_W-1:0] peak_level,
  input logic [VAL_W-1:0] capture_time,
  input logic             last_of_burst
);

  // no request taken while a result is pending
  a_ready_no_result: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("request taken while result pending");

  // a sample request leaves the block busy
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && command == CMD_SAMPLE) |=> !in_ready)
    else $error("ready after sample request");

  // tick, sync and unused commands finish at once
  a_other_quick: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && command != CMD_SAMPLE) |=> in_ready)
    else $error("not ready after non-sample request");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (capture_time <= VAL_W'(FRAME_LENGTH)))
    else $error("capture time out of range");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(peak_level) && $stable(capture_time) && $stable(last_of_burst)))
    else $error("stalled result changed");

endmodule

bind loudest_sample_capture_report lscr_checker #(.FRAME_LENGTH(FRAME_LENGTH)) u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (sample_ch.valid),
  .in_ready      (sample_ch.ready),
  .command       (sample_ch.command),
  .out_valid     (report_ch.valid),
  .out_ready     (report_ch.ready),
  .peak_level    (report_ch.peak_level),
  .capture_time  (report_ch.capture_time),
  .last_of_burst (report_ch.last_of_burst)
);
